>>> hw/rtl/wecl_pkg.sv
// ---------------------------------------------------------------------------
// wecl_pkg - shared types and codes for the windowed event count log
// Operation codes and the command/status bundles between controller and
// datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package wecl_pkg;

    localparam logic [1:0] OP_LOG    = 2'd0;
    localparam logic [1:0] OP_WINDOW = 2'd1;
    localparam logic [1:0] OP_SINCE  = 2'd2;
    localparam logic [1:0] OP_RECENT = 2'd3;

    localparam logic [6:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic log_wr;     // store the request as the newest entry
        logic load;       // set up a query walk
        logic walk;       // advance the walk by one entry
        logic fin_log;    // capture a log acknowledge
        logic fin_query;  // capture the query sum
    } wecl_cmd_t;

    typedef struct packed {
        logic walk_done;
    } wecl_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/wecl_datapath.sv
// ---------------------------------------------------------------------------
// wecl_datapath - history memory, ring pointers and window accumulator
// Holds the stamp and amount ring, the capacity register, and walks the
// entries newest first, one memory read a cycle, with a one-deep read pipe.
// ---------------------------------------------------------------------------
`default_nettype none

module wecl_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wecl_pkg::wecl_cmd_t   cmd,
    output wecl_pkg::wecl_status_t     status,
    input  wire logic [1:0]            op,
    input  wire logic signed [31:0]    now_time,
    input  wire logic [31:0]           amount,
    input  wire logic signed [31:0]    start_time,
    input  wire logic signed [31:0]    end_time,
    input  wire logic signed [31:0]    window_seconds,
    input  wire logic                  cfg_wr,
    input  wire logic [6:0]            cfg_data,
    output logic [31:0]                total,
    output logic                       answered
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] cap_of(input logic [6:0] lim);
        int l;
        l = int'(lim);
        if (l < 3) l = 3;
        if (l > DEPTH) l = DEPTH;
        return AW'(l - 1);
    endfunction

    logic [31:0]        stamp_mem  [DEPTH];
    logic [31:0]        amount_mem [DEPTH];

    logic [6:0]         limit_reg,  limit_next;
    logic [AW-1:0]      newest_reg, newest_next;
    logic [AW-1:0]      held_reg,   held_next;
    logic [AW-1:0]      slot_reg,   slot_next;
    logic [AW-1:0]      left_reg,   left_next;
    logic               pend_reg,   pend_next;
    logic               stop_reg,   stop_next;
    logic signed [31:0] win_lo_reg, win_lo_next;
    logic signed [31:0] win_hi_reg, win_hi_next;
    logic [31:0]        acc_reg,    acc_next;
    logic [31:0]        total_reg,  total_next;
    logic               answered_reg, answered_next;

    logic signed [31:0] rd_stamp_reg;
    logic [31:0]        rd_amount_reg;

    logic [AW-1:0]      cap_now;
    logic [AW-1:0]      cap_cfg;
    logic [AW-1:0]      wr_slot;
    logic               issue;

    assign cap_now = cap_of(limit_reg);
    assign cap_cfg = cap_of(cfg_data);
    assign wr_slot = (newest_reg == LAST_SLOT) ? '0 : newest_reg + AW'(1);
    assign issue   = cmd.walk && (left_reg != '0) && !stop_reg;

    always_comb
    begin
        limit_next    = limit_reg;
        newest_next   = newest_reg;
        held_next     = held_reg;
        slot_next     = slot_reg;
        left_next     = left_reg;
        pend_next     = pend_reg;
        stop_next     = stop_reg;
        win_lo_next   = win_lo_reg;
        win_hi_next   = win_hi_reg;
        acc_next      = acc_reg;
        total_next    = total_reg;
        answered_next = answered_reg;

        if (cfg_wr)
        begin
            limit_next = cfg_data;
            // drop the oldest entries down to the new capacity
            if (held_reg > cap_cfg)
                held_next = cap_cfg;
        end

        if (cmd.log_wr)
        begin
            newest_next = wr_slot;
            held_next   = (held_reg < cap_now) ? held_reg + AW'(1) : cap_now;
        end

        if (cmd.load)
        begin
            slot_next = newest_reg;
            left_next = held_reg;
            pend_next = 1'b0;
            stop_next = 1'b0;
            acc_next  = '0;
            case (op)
                wecl_pkg::OP_WINDOW:
                begin
                    win_lo_next = start_time;
                    win_hi_next = end_time;
                end
                wecl_pkg::OP_SINCE:
                begin
                    win_lo_next = start_time;
                    win_hi_next = now_time;
                end
                default:
                begin
                    win_lo_next = now_time - window_seconds;
                    win_hi_next = now_time;
                end
            endcase
        end

        if (cmd.walk)
        begin
            pend_next = issue;
            if (issue)
            begin
                slot_next = (slot_reg == '0) ? LAST_SLOT : slot_reg - AW'(1);
                left_next = left_reg - AW'(1);
            end
            // evaluate the entry read last cycle; anything after a stop is ignored
            if (pend_reg && !stop_reg)
            begin
                if (rd_stamp_reg < win_lo_reg)
                    stop_next = 1'b1;
                else if (rd_stamp_reg <= win_hi_reg)
                    acc_next = acc_reg + rd_amount_reg;
            end
        end

        if (cmd.fin_log)
        begin
            total_next    = '0;
            answered_next = 1'b0;
        end

        if (cmd.fin_query)
        begin
            total_next    = acc_reg;
            answered_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= wecl_pkg::LIMIT_RESET;
            newest_reg <= '0;
            held_reg   <= '0;
            left_reg   <= '0;
            pend_reg   <= 1'b0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            limit_reg  <= limit_next;
            newest_reg <= newest_next;
            held_reg   <= held_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            stop_reg   <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        win_lo_reg   <= win_lo_next;
        win_hi_reg   <= win_hi_next;
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        answered_reg <= answered_next;
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.log_wr)
        begin
            stamp_mem[wr_slot]  <= now_time;
            amount_mem[wr_slot] <= amount;
        end
        if (issue)
        begin
            rd_stamp_reg  <= stamp_mem[slot_reg];
            rd_amount_reg <= amount_mem[slot_reg];
        end
    end

    assign status.walk_done = stop_reg || ((left_reg == '0) && !pend_reg);
    assign total            = total_reg;
    assign answered         = answered_reg;

    held_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= cap_now)
        else $error("held count exceeds capacity");

    newest_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        newest_reg <= LAST_SLOT)
        else $error("newest slot outside the ring");

    load_clears_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (acc_reg == '0) && !pend_reg && !stop_reg && (left_reg == $past(held_reg)))
        else $error("query walk not set up from the held count");

endmodule

`default_nettype wire

>>> hw/rtl/wecl_ctrl.sv
// ---------------------------------------------------------------------------
// wecl_ctrl - request sequencer for the windowed event count log
// Accepts requests, runs the query walk and raises the result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module wecl_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [1:0]             op,
    input  wire wecl_pkg::wecl_status_t status,
    output wecl_pkg::wecl_cmd_t         cmd,
    output logic                        busy,
    output logic                        done
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg,  done_next;
    logic   take;

    assign busy = (state_reg != S_IDLE);
    assign take = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (op == wecl_pkg::OP_LOG)
                    begin
                        cmd.log_wr  = 1'b1;
                        cmd.fin_log = 1'b1;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    cmd.fin_query = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    log_acks_next_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op == wecl_pkg::OP_LOG) |=> done && !busy)
        else $error("log request not acknowledged in the next cycle");

    walk_end_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && status.walk_done) |=> done && !busy)
        else $error("finished walk gave no answer");

    done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(take) || $past(state_reg == S_WALK)))
        else $error("result strobe without a request");

endmodule

`default_nettype wire

>>> hw/rtl/windowed_event_count_log.sv
// ---------------------------------------------------------------------------
// windowed_event_count_log - bounded event history with windowed sums
// Logs (time, amount) events into a ring and answers window sum queries.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A log request
// is acknowledged in the cycle after it is taken: done pulses with answered
// low and total zero, and logs may follow back to back. A query walks the
// held entries newest first through the single read port of the history
// memory, one entry a cycle, while busy stays high; done pulses as busy
// falls, with the sum and answered high. Results are shown for exactly
// one cycle and cannot be held off. Configuration writes are taken only
// while busy is low and no request is offered on start.
// ---------------------------------------------------------------------------
`default_nettype none

module windowed_event_count_log #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] now_time,
    input  wire logic [31:0]        amount,
    input  wire logic signed [31:0] start_time,
    input  wire logic signed [31:0] end_time,
    input  wire logic signed [31:0] window_seconds,
    output logic                    done,
    output logic [31:0]             total,
    output logic                    answered,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [6:0]         cfg_data
);

    wecl_pkg::wecl_cmd_t    cmd;
    wecl_pkg::wecl_status_t status;

    // hold the write off while busy or while a request is being offered
    assign cfg_ready = !busy && !start;

    wecl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    wecl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .op             (op),
        .now_time       (now_time),
        .amount         (amount),
        .start_time     (start_time),
        .end_time       (end_time),
        .window_seconds (window_seconds),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .total          (total),
        .answered       (answered)
    );

endmodule

`default_nettype wire
